>>> rtl/mau_pkg.sv
// Package for the modular arithmetic unit: widths, command codes, request and
// response structs, divider control and status structs. No dependencies.
package mau_pkg;

   localparam int unsigned OpW  = 31;
   localparam int unsigned ExpW = 63;
   localparam int unsigned RawW = 64;
   localparam int unsigned CmdW = 3;
   localparam int unsigned DivW = 64;   // dividend width of the shared divider
   localparam int unsigned CntW = 7;    // divider step / bit counter

   localparam logic [OpW-1:0] DefaultModulus = OpW'(1000000007);

   typedef enum logic [CmdW-1:0] {
      CMD_REDUCE = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_SUB    = 3'd2,
      CMD_MUL    = 3'd3,
      CMD_DIV    = 3'd4,
      CMD_POW    = 3'd5,
      CMD_INV    = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic [OpW-1:0]  first_operand;
      logic [OpW-1:0]  second_operand;
      logic [ExpW-1:0] exponent;
      logic [RawW-1:0] raw_value;
   } req_type;

   typedef struct packed {
      logic [OpW-1:0] result;
      logic           zero_divisor;
   } rsp_type;

   // Divider control between sequencer and shared divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_sts_type;

endpackage

>>> rtl/mau_divider.sv
// Shared restoring divider: 64-bit dividend by 31-bit divisor, one quotient
// bit per cycle. Depends on mau_pkg.
module mau_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  mau_pkg::div_ctl_type         ctl,
   input  logic [mau_pkg::DivW-1:0]     dividend,
   input  logic [mau_pkg::OpW-1:0]      divisor,
   output mau_pkg::div_sts_type         sts,
   output logic [mau_pkg::DivW-1:0]     quotient,
   output logic [mau_pkg::OpW-1:0]      remainder
);

   logic [mau_pkg::DivW-1:0] quo_ff, quo_in;
   logic [mau_pkg::OpW:0]    rem_ff, rem_in;
   logic [mau_pkg::OpW-1:0]  dsr_ff, dsr_in;
   logic [mau_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [mau_pkg::OpW+1:0]  trial;
   logic [mau_pkg::OpW:0]    shifted;

   // Load the operands on start, else one shift-subtract step while busy
   always_comb begin
      shifted = {rem_ff[mau_pkg::OpW-1:0], quo_ff[mau_pkg::DivW-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = mau_pkg::CntW'(mau_pkg::DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[mau_pkg::OpW+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[mau_pkg::DivW-2:0], 1'b0};
         end else begin
            rem_in = trial[mau_pkg::OpW:0];
            quo_in = {quo_ff[mau_pkg::DivW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mau_pkg::CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done  = done_ff;
   assign sts.busy  = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[mau_pkg::OpW-1:0];

   // Divisor is nonzero whenever a step runs
   a_dsr_nz: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> dsr_ff != '0) else $error("divider: zero divisor");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider: done held");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("divider: start while busy");

endmodule

>>> rtl/modular_arithmetic_unit.sv
// Modular arithmetic unit over a prime modulus: sequencer plus shared divider.
// Depends on mau_pkg and mau_divider.
// Reduce is a single divider pass; other commands first reduce both operands.
// Multiply then reduces the product; power makes a pass per multiply or square
// (up to 126); invert makes two passes per quotient step, divide the same plus
// a final product (step count depends on the operand). A divider pass is 64 steps.
// One request at a time; busy drops with the strobe, when a new start can be taken.
// Reset: synchronous, returns to idle and loads modulus 1000000007. No receiver stall.
module modular_arithmetic_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mau_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output mau_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [mau_pkg::OpW-1:0]       csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RA    = 9'b000000010,  // reduce a
      ST_RB    = 9'b000000100,  // reduce b
      ST_OP    = 9'b000001000,  // dispatch after operands reduced
      ST_MUL   = 9'b000010000,  // waiting on a product reduction
      ST_PSQ   = 9'b000100000,  // power: multiply and square
      ST_IQ    = 9'b001000000,  // invert and divide: m / t
      ST_IACC  = 9'b010000000,  // invert and divide: acc * (m - q)
      ST_DONE  = 9'b100000000
   } state_type;

   localparam int unsigned W = mau_pkg::OpW;

   state_type               state_ff, state_in;
   logic [W-1:0]            mod_ff, mod_in;
   logic [W-1:0]            m_ff, m_in;
   logic [mau_pkg::CmdW-1:0] cmd_ff, cmd_in;
   logic [W-1:0]            a_ff, a_in;
   logic [W-1:0]            b_ff, b_in;
   logic [mau_pkg::ExpW-1:0] e_ff, e_in;
   logic [W-1:0]            acc_ff, acc_in;
   logic [W-1:0]            t_ff, t_in;
   logic [W-1:0]            q_ff, q_in;
   logic                    neg_ff, neg_in;
   logic                    mulsel_ff, mulsel_in; // power: 1 = acc*cur pending
   logic                    rv_ff, rv_in;
   mau_pkg::rsp_type        rsp_ff, rsp_in;

   mau_pkg::div_ctl_type    dctl;
   mau_pkg::div_sts_type    dsts;
   logic [mau_pkg::DivW-1:0] dvd;
   logic [W-1:0]            dvsr;
   logic [mau_pkg::DivW-1:0] dquo;
   logic [W-1:0]            drem;
   logic [2*W-1:0]          prod;
   logic [W-1:0]            mul_x, mul_y;
   logic [W:0]              sum;
   logic [W:0]              diff;
   logic [W-1:0]            rmod;
   logic [W-1:0]            m_eff;

   mau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dctl),
      .dividend  (dvd),
      .divisor   (dvsr),
      .sts       (dsts),
      .quotient  (dquo),
      .remainder (drem)
   );

   // Single shared multiplier, its product is reduced by the divider
   assign prod  = mul_x * mul_y;
   assign sum   = {1'b0, a_ff} + {1'b0, b_ff};
   assign diff  = {1'b0, a_ff} + {1'b0, m_ff} - {1'b0, b_ff};
   assign rmod  = (drem == '0) ? '0 : m_ff - drem;
   assign m_eff = (mod_ff == '0) ? W'(1) : mod_ff;

   always_comb begin
      state_in  = state_ff;
      mod_in    = mod_ff;
      m_in      = m_ff;
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      acc_in    = acc_ff;
      t_in      = t_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      mulsel_in = mulsel_ff;
      rv_in     = 1'b0;
      rsp_in    = rsp_ff;
      dctl.start = 1'b0;
      dvd       = '0;
      dvsr      = m_ff;
      mul_x     = acc_ff;
      mul_y     = a_ff;
      if (csr_write) mod_in = csr_wdata;

      case (state_ff)
         ST_IDLE: begin
            // divider latches its divisor now, so feed it the live modulus
            dvsr = m_eff;
            if (start) begin
               m_in   = m_eff;
               cmd_in = req_data.cmd;
               a_in   = req_data.first_operand;
               b_in   = req_data.second_operand;
               e_in   = req_data.exponent;
               neg_in = req_data.raw_value[mau_pkg::RawW-1];
               state_in = ST_RA;
               dctl.start = 1'b1;
               if (req_data.cmd == mau_pkg::CMD_REDUCE) begin
                  dvd = req_data.raw_value[mau_pkg::RawW-1] ?
                        (mau_pkg::RawW'(0) - req_data.raw_value) :
                        req_data.raw_value;
               end else begin
                  dvd = mau_pkg::DivW'(req_data.first_operand);
               end
            end
         end
         ST_RA: begin
            if (dsts.done) begin
               if (cmd_ff == mau_pkg::CMD_REDUCE) begin
                  rsp_in.result = neg_ff ? rmod : drem;
                  rsp_in.zero_divisor = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  a_in = drem;
                  dctl.start = 1'b1;
                  dvd = mau_pkg::DivW'(b_ff);
                  state_in = ST_RB;
               end
            end
         end
         ST_RB: begin
            if (dsts.done) begin
               b_in = drem;
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            rsp_in.zero_divisor = 1'b0;
            rsp_in.result = '0;
            state_in = ST_DONE;
            acc_in = (m_ff == W'(1)) ? '0 : W'(1);
            case (cmd_ff)
               mau_pkg::CMD_ADD: rsp_in.result =
                  (sum >= {1'b0, m_ff}) ? W'(sum - {1'b0, m_ff}) : sum[W-1:0];
               mau_pkg::CMD_SUB: rsp_in.result =
                  (diff >= {1'b0, m_ff}) ? W'(diff - {1'b0, m_ff}) : diff[W-1:0];
               mau_pkg::CMD_MUL: begin
                  mul_x = a_ff; mul_y = b_ff;
                  dvd = mau_pkg::DivW'(prod);
                  dctl.start = 1'b1;
                  state_in = ST_MUL;
               end
               mau_pkg::CMD_POW: begin
                  // a already reduced; acc = 1 mod m
                  state_in = ST_PSQ;
                  mulsel_in = 1'b0;
                  q_in = '0;
                  if (e_ff == '0) begin
                     rsp_in.result = (m_ff == W'(1)) ? '0 : W'(1);
                     state_in = ST_DONE;
                  end
               end
               mau_pkg::CMD_DIV, mau_pkg::CMD_INV: begin
                  t_in = (cmd_ff == mau_pkg::CMD_DIV) ? b_ff : a_ff;
                  state_in = ST_IQ;
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            if (dsts.done) begin
               rsp_in.result = drem;
               state_in = ST_DONE;
            end
         end
         // Power: each exponent bit does optional acc*cur then cur*cur
         ST_PSQ: begin
            if (!dsts.busy && !dsts.done) begin
               if (e_ff == '0) begin
                  rsp_in.result = acc_ff;
                  state_in = ST_DONE;
               end else if (e_ff[0] && !mulsel_ff) begin
                  mul_x = acc_ff; mul_y = a_ff;
                  dvd = mau_pkg::DivW'(prod);
                  dctl.start = 1'b1;
                  mulsel_in = 1'b1;
               end else begin
                  mul_x = a_ff; mul_y = a_ff;
                  dvd = mau_pkg::DivW'(prod);
                  dctl.start = 1'b1;
                  mulsel_in = 1'b0;
                  e_in = e_ff >> 1;
                  q_in = '1; // marks square pending
               end
            end else if (dsts.done) begin
               if (q_ff == '1) begin
                  a_in = drem;
                  q_in = '0;
               end else begin
                  acc_in = drem;
               end
            end
         end
         // Invert and divide: t <- m mod t, acc <- acc*(m - m/t)
         ST_IQ: begin
            if (!dsts.busy && !dsts.done) begin
               if (t_ff == '0) begin
                  rsp_in.result = '0;
                  rsp_in.zero_divisor = 1'b1;
                  state_in = ST_DONE;
               end else if (t_ff == W'(1)) begin
                  if (cmd_ff == mau_pkg::CMD_INV) begin
                     rsp_in.result = acc_ff;
                     state_in = ST_DONE;
                  end else begin
                     mul_x = acc_ff; mul_y = a_ff;
                     dvd = mau_pkg::DivW'(prod);
                     dctl.start = 1'b1;
                     state_in = ST_MUL;
                  end
               end else begin
                  // m / t on the shared divider
                  dvd = mau_pkg::DivW'(m_ff);
                  dvsr = t_ff;
                  dctl.start = 1'b1;
               end
            end else if (dsts.done) begin
               q_in = dquo[W-1:0];
               t_in = drem;
               state_in = ST_IACC;
            end
         end
         ST_IACC: begin
            mul_x = acc_ff; mul_y = m_ff - q_ff;
            if (!dsts.busy && !dsts.done) begin
               dvd = mau_pkg::DivW'(prod);
               dctl.start = 1'b1;
            end else if (dsts.done) begin
               acc_in = drem;
               state_in = ST_IQ;
            end
         end
         ST_DONE: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff   <= mau_pkg::DefaultModulus;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
         rv_ff    <= rv_in;
      end
      m_ff      <= m_in;
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      e_ff      <= e_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      mulsel_ff <= mulsel_in;
      rsp_ff    <= rsp_in;
      q_ff      <= q_in;
      t_ff      <= t_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> $past(state_ff == ST_DONE)) else $error("strobe without done");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rsp_ff.result < m_ff || m_ff == '0) else $error("result out of range");
   a_zd: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.zero_divisor |-> rsp_ff.result == '0)
      else $error("zero divisor with nonzero result");

endmodule

>>> dv/tb.sv
// Self-checking testbench for modular_arithmetic_unit: directed and random requests
// under several moduli, checked against a built-in predictor. Depends on mau_pkg.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned StallLimit = 400000;
   localparam int unsigned DrainWait  = 200;

   // Expected-result store plus the arithmetic that predicts each result
   class mod_result_board;
      mau_pkg::rsp_type pending[$];

      function automatic longint unsigned field_mod(logic [mau_pkg::OpW-1:0] m);
         return (m == 0) ? 64'd1 : 64'(m);
      endfunction

      // Quotient-loop inverse; returns 0 when t reaches 0 before 1
      function automatic bit find_inverse(longint unsigned a, longint unsigned m,
                                          output longint unsigned inv);
         longint unsigned t, acc, q;
         t   = a % m;
         acc = 1 % m;
         while (t > 1) begin
            q   = m / t;
            acc = (acc * (m - q)) % m;
            t   = m - t * q;
         end
         inv = (t == 0) ? 64'd0 : acc;
         return t != 0;
      endfunction

      function automatic mau_pkg::rsp_type predict(mau_pkg::req_type r,
                                                   logic [mau_pkg::OpW-1:0] modulus);
         longint unsigned m, a, b, e, acc, cur, inv, mag;
         mau_pkg::rsp_type p;
         m = field_mod(modulus);
         a = 64'(r.first_operand) % m;
         b = 64'(r.second_operand) % m;
         p = '0;
         case (mau_pkg::cmd_type'(r.cmd))
            mau_pkg::CMD_REDUCE: begin
               if (!r.raw_value[mau_pkg::RawW-1]) begin
                  p.result = mau_pkg::OpW'(r.raw_value % m);
               end else begin
                  mag = (64'd0 - r.raw_value) % m;
                  p.result = mau_pkg::OpW'((mag == 0) ? 64'd0 : m - mag);
               end
            end
            mau_pkg::CMD_ADD: p.result = mau_pkg::OpW'((a + b) % m);
            mau_pkg::CMD_SUB: p.result = mau_pkg::OpW'((a + m - b) % m);
            mau_pkg::CMD_MUL: p.result = mau_pkg::OpW'((a * b) % m);
            mau_pkg::CMD_DIV: begin
               if (find_inverse(b, m, inv)) p.result = mau_pkg::OpW'((a * inv) % m);
               else p.zero_divisor = 1'b1;
            end
            mau_pkg::CMD_POW: begin
               acc = 1 % m;
               cur = a;
               e   = 64'(r.exponent);
               while (e != 0) begin
                  if (e[0]) acc = (acc * cur) % m;
                  cur = (cur * cur) % m;
                  e   = e >> 1;
               end
               p.result = mau_pkg::OpW'(acc);
            end
            mau_pkg::CMD_INV: begin
               if (find_inverse(a, m, inv)) p.result = mau_pkg::OpW'(inv);
               else p.zero_divisor = 1'b1;
            end
            default: ;
         endcase
         return p;
      endfunction

      function void note_request(mau_pkg::req_type r, logic [mau_pkg::OpW-1:0] modulus);
         pending.push_back(predict(r, modulus));
      endfunction

      // Returns 1 on a match; msg describes any mismatch
      function bit check_result(mau_pkg::rsp_type got, output string msg);
         mau_pkg::rsp_type exp_rsp;
         msg = "";
         if (pending.size() == 0) begin
            msg = $sformatf("result %0d/%0d with no request outstanding",
                            got.result, got.zero_divisor);
            return 0;
         end
         exp_rsp = pending.pop_front();
         if (got.result !== exp_rsp.result)
            msg = $sformatf("result %0d, expected %0d", got.result, exp_rsp.result);
         if (got.zero_divisor !== exp_rsp.zero_divisor)
            msg = {msg, $sformatf(" zero_divisor %0b, expected %0b",
                                  got.zero_divisor, exp_rsp.zero_divisor)};
         return msg == "";
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   mau_pkg::req_type        req_data;
   logic                    rsp_valid;
   mau_pkg::rsp_type        rsp_data;
   logic                    csr_write;
   logic [mau_pkg::OpW-1:0] csr_wdata;

   mod_result_board         board;
   logic [mau_pkg::OpW-1:0] modulus_now;
   int unsigned             mismatches;
   int unsigned             stall_count;
   int unsigned             item_count;

   modular_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Note accepted requests, check results, watch for a stalled block
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (start && !busy) board.note_request(req_data, modulus_now);
         if (rsp_valid && !board.check_result(rsp_data, msg)) report_mismatch(msg);
         if ((start && !busy) || rsp_valid) begin
            stall_count = 0;
         end else begin
            stall_count++;
            if (stall_count >= StallLimit) begin
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   function automatic mau_pkg::req_type make_req(mau_pkg::cmd_type c,
                                                 logic [mau_pkg::OpW-1:0] a,
                                                 logic [mau_pkg::OpW-1:0] b,
                                                 logic [mau_pkg::ExpW-1:0] e,
                                                 logic [mau_pkg::RawW-1:0] raw);
      mau_pkg::req_type r;
      r.cmd            = c;
      r.first_operand  = a;
      r.second_operand = b;
      r.exponent       = e;
      r.raw_value      = raw;
      return r;
   endfunction

   function automatic logic [mau_pkg::OpW-1:0] rand_operand();
      longint unsigned m;
      m = (modulus_now == 0) ? 64'd1 : 64'(modulus_now);
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return mau_pkg::OpW'(m - 1);
         2:       return '0;
         3, 4:    return mau_pkg::OpW'($urandom);
         default: return mau_pkg::OpW'($urandom % m);
      endcase
   endfunction

   function automatic mau_pkg::req_type rand_req();
      logic [mau_pkg::ExpW-1:0] e;
      case ($urandom_range(0, 19))
         0:       e = mau_pkg::ExpW'({$urandom, $urandom});
         1, 2:    e = mau_pkg::ExpW'($urandom_range(0, 2000));
         default: e = mau_pkg::ExpW'($urandom_range(0, 40));
      endcase
      return make_req(mau_pkg::cmd_type'($urandom_range(0, 7)), rand_operand(),
                      rand_operand(), e, {$urandom, $urandom});
   endfunction

   // Offer one request; start stays high until it is taken
   task automatic send_request(mau_pkg::req_type r, bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 32) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      item_count++;
   endtask

   // Stop offering and wait until every outstanding request has answered
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_modulus(logic [mau_pkg::OpW-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write   <= 1'b0;
      modulus_now  = value;
   endtask

   task automatic random_phase(int unsigned count);
      repeat (count) send_request(rand_req(), !(item_count >= 70 && item_count < 100));
   endtask

   initial begin
      logic [mau_pkg::OpW-1:0] moduli[7];
      logic [mau_pkg::OpW-1:0] top;
      board       = new();
      mismatches  = 0;
      stall_count = 0;
      item_count  = 0;
      modulus_now = mau_pkg::DefaultModulus;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_wdata   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every command, zero divisors, zero exponent
      top = mau_pkg::DefaultModulus - 1'b1;
      send_request(make_req(mau_pkg::CMD_REDUCE, 0, 0, 0, 64'h7fff_ffff_ffff_ffff), 0);
      send_request(make_req(mau_pkg::CMD_REDUCE, 0, 0, 0, 64'h8000_0000_0000_0000), 0);
      send_request(make_req(mau_pkg::CMD_REDUCE, 0, 0, 0, '1), 0);
      send_request(make_req(mau_pkg::CMD_REDUCE, 0, 0, 0, -64'sd1000000007), 0);
      send_request(make_req(mau_pkg::CMD_REDUCE, 0, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_ADD, top, top, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_ADD, '1, '1, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_SUB, 0, top, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_SUB, '1, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_MUL, top, top, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_MUL, '1, '1, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_DIV, 12345, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_DIV, 12345, mau_pkg::DefaultModulus, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_DIV, top, 3, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_INV, 0, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_INV, 1, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_INV, top, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_INV, '1, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_POW, 7, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_POW, 0, 0, 0, 0), 0);
      send_request(make_req(mau_pkg::CMD_POW, top, 0, '1, 0), 0);
      send_request(make_req(mau_pkg::CMD_POW, 2, 0, 64'd1000000006, 0), 0);
      send_request(make_req(mau_pkg::CMD_NONE, '1, '1, '1, '1), 0);
      drain();

      // Random requests across moduli: max prime, smallest, degenerate, composite
      random_phase(15);
      moduli = '{31'h7fff_ffff, 31'd2, 31'd0, 31'd1, 31'd15, 31'd65521,
                 mau_pkg::DefaultModulus};
      foreach (moduli[i]) begin
         drain();
         write_modulus(moduli[i]);
         random_phase(14);
      end

      drain();
      if (board.pending.size() != 0) report_mismatch("results still outstanding at end");
      repeat (DrainWait) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mau_pkg.sv
rtl/mau_divider.sv
rtl/modular_arithmetic_unit.sv
dv/tb.sv
